[rtl/core/msr_pkg.sv]
// Shared types, constants and the clamp helper function of the motion setpoint ramp.
`default_nettype none

package msr_pkg;

  // Fixed field widths of the request, result and configuration channels.
  localparam int FIELD_W      = 16;
  localparam int LIMIT_W      = 15;
  localparam int TICKS_W      = 8;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 16;

  // Default width of the value range that caps the limits.
  localparam int VALUE_WIDTH_DEF = 16;

  // Stop braking: speed magnitude threshold and the 0.6 factor as 154/256.
  localparam logic [FIELD_W-1:0] BRAKE_THRESHOLD = 16'd50;
  localparam logic [7:0]         BRAKE_NUM       = 8'd154;

  // Configuration reset values.
  localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RST = 15'd1000;
  localparam logic [LIMIT_W-1:0] TURN_LIMIT_RST  = 15'd30000;
  localparam logic [LIMIT_W-1:0] SPEED_RATE_RST  = 15'd10;
  localparam logic [LIMIT_W-1:0] TURN_RATE_RST   = 15'd100;
  localparam logic [TICKS_W-1:0] BRAKE_TICKS_RST = 8'd20;

  typedef enum logic [1:0] {
    MODE_STOP   = 2'd0,
    MODE_MANUAL = 2'd1,
    MODE_AUTO   = 2'd2
  } msr_mode_t;

  typedef enum logic [2:0] {
    CMD_TICK       = 3'd0,
    CMD_SET_MODE   = 3'd1,
    CMD_FORWARD    = 3'd2,
    CMD_TURN       = 3'd3,
    CMD_SET_TARGET = 3'd4,
    CMD_ROTATE     = 3'd5,
    CMD_STRAIGHT   = 3'd6,
    CMD_STOP       = 3'd7
  } msr_cmd_code_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SPEED_LIMIT = 3'd0,
    CFG_TURN_LIMIT  = 3'd1,
    CFG_SPEED_RATE  = 3'd2,
    CFG_TURN_RATE   = 3'd3,
    CFG_BRAKE_TICKS = 3'd4
  } msr_cfg_index_t;

  // Request payload.
  typedef struct packed {
    logic [2:0]                command;
    logic [1:0]                mode_value;
    logic signed [FIELD_W-1:0] speed_arg;
    logic signed [FIELD_W-1:0] turn_arg;
    logic signed [FIELD_W-1:0] remote_speed;
    logic signed [FIELD_W-1:0] remote_turn;
  } msr_cmd_t;

  // Result payload.
  typedef struct packed {
    logic signed [FIELD_W-1:0] drive_speed;
    logic signed [FIELD_W-1:0] drive_turn;
    logic [1:0]                mode_now;
    logic                      braking;
  } msr_res_t;

  // Configuration write payload.
  typedef struct packed {
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } msr_cfg_t;

  // Limits and steps handed from the register file to the datapath.
  typedef struct packed {
    logic [LIMIT_W-1:0] speed_limit;
    logic [LIMIT_W-1:0] turn_limit;
    logic [LIMIT_W-1:0] speed_rate;
    logic [LIMIT_W-1:0] turn_rate;
    logic [TICKS_W-1:0] brake_ticks;
  } msr_limits_t;

  // Clamp a signed value to the symmetric range [-lim, lim].
  function automatic logic signed [FIELD_W-1:0] clamp_lim(
    input logic signed [FIELD_W-1:0] v,
    input logic [LIMIT_W-1:0]        lim
  );
    logic signed [FIELD_W:0] ve;
    logic signed [FIELD_W:0] l;
    logic signed [FIELD_W:0] nl;
    ve = {v[FIELD_W-1], v};
    l  = signed'({2'b00, lim});
    nl = -l;
    if (ve > l) begin
      return l[FIELD_W-1:0];
    end
    if (ve < nl) begin
      return nl[FIELD_W-1:0];
    end
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/core/msr_chan_if.sv]
// Valid/ready channel interface carrying one payload per request.
`default_nettype none

interface msr_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/core/motion_setpoint_ramp.sv]
// Top level of the two-channel slew-limited speed and turn setpoint generator.
`default_nettype none

// The block takes one request per clock cycle unless the result side stalls, and returns
// one result for each, in order. A request is taken into an input register; once the
// result register is free, one pass of clamp, slew and mode logic updates the state and
// loads the result register, which then offers the result. Both registers move as soon
// as the stage after them is free, so a waiting result does not stop a new request from
// entering an empty input register. Configuration writes are always taken and should
// be made only while no request is in flight.
module motion_setpoint_ramp #(
  parameter int VALUE_WIDTH = msr_pkg::VALUE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  msr_chan_if.sink  cmd,
  msr_chan_if.sink  cfg,
  msr_chan_if.source res
);
  import msr_pkg::*;

  msr_limits_t limits;

  // Pipeline registers.
  logic     in_busy;
  msr_cmd_t in_item;
  logic     out_busy;
  msr_res_t out_item;
  logic     adv;

  // Block state.
  msr_mode_t                 mode_reg;
  logic signed [FIELD_W-1:0] auto_speed;
  logic signed [FIELD_W-1:0] auto_turn;
  logic signed [FIELD_W-1:0] cur_speed;
  logic signed [FIELD_W-1:0] cur_turn;
  logic [TICKS_W-1:0]        brake_left;

  msr_mode_t                 mode_reg_next;
  logic signed [FIELD_W-1:0] auto_speed_next;
  logic signed [FIELD_W-1:0] auto_turn_next;
  logic signed [FIELD_W-1:0] cur_speed_next;
  logic signed [FIELD_W-1:0] cur_turn_next;
  logic [TICKS_W-1:0]        brake_left_next;

  logic signed [FIELD_W-1:0] goal_speed;
  logic signed [FIELD_W-1:0] goal_turn;
  logic signed [FIELD_W-1:0] slew_speed;
  logic signed [FIELD_W-1:0] slew_turn;
  logic [FIELD_W-1:0]        speed_mag;
  logic [FIELD_W+7:0]        brake_prod;
  logic [FIELD_W-1:0]        brake_mag;
  logic                      mode_ok;

  msr_cfg_regs #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_cfg (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .limits (limits)
  );

  // Target selection by mode for the tick.
  always_comb begin
    case (mode_reg)
      MODE_MANUAL: begin
        goal_speed = in_item.remote_speed;
        goal_turn  = in_item.remote_turn;
      end
      MODE_AUTO: begin
        goal_speed = auto_speed;
        goal_turn  = auto_turn;
      end
      default: begin
        goal_speed = '0;
        goal_turn  = '0;
      end
    endcase
  end

  msr_slew u_slew_speed (
    .cur   (cur_speed),
    .want  (goal_speed),
    .limit (limits.speed_limit),
    .step  (limits.speed_rate),
    .next  (slew_speed)
  );

  msr_slew u_slew_turn (
    .cur   (cur_turn),
    .want  (goal_turn),
    .limit (limits.turn_limit),
    .step  (limits.turn_rate),
    .next  (slew_turn)
  );

  // Brake target magnitude: current speed magnitude times 154/256.
  always_comb begin
    speed_mag  = cur_speed[FIELD_W-1] ? FIELD_W'(-cur_speed) : FIELD_W'(cur_speed);
    brake_prod = speed_mag * BRAKE_NUM;
    brake_mag  = brake_prod[FIELD_W+7:8];
    mode_ok    = (in_item.mode_value inside {MODE_STOP, MODE_MANUAL, MODE_AUTO}) &&
                 (in_item.mode_value != mode_reg);
  end

  // Next state for the item in the input register.
  always_comb begin
    mode_reg_next   = mode_reg;
    auto_speed_next = auto_speed;
    auto_turn_next  = auto_turn;
    cur_speed_next  = cur_speed;
    cur_turn_next   = cur_turn;
    brake_left_next = brake_left;
    if (in_item.command == CMD_TICK) begin
      cur_speed_next = slew_speed;
      cur_turn_next  = slew_turn;
      if (brake_left != '0) begin
        brake_left_next = brake_left - 1'b1;
        if (brake_left == TICKS_W'(1)) begin
          auto_speed_next = '0;
          auto_turn_next  = '0;
          mode_reg_next   = MODE_STOP;
        end
      end
    end else if (brake_left == '0) begin
      case (in_item.command)
        CMD_SET_MODE: begin
          if (mode_ok) begin
            mode_reg_next = msr_mode_t'(in_item.mode_value);
            if (in_item.mode_value != MODE_AUTO) begin
              auto_speed_next = '0;
              auto_turn_next  = '0;
            end
          end
        end
        CMD_FORWARD: begin
          auto_speed_next = clamp_lim(in_item.speed_arg, limits.speed_limit);
          mode_reg_next   = MODE_AUTO;
        end
        CMD_TURN: begin
          auto_turn_next = clamp_lim(in_item.turn_arg, limits.turn_limit);
          mode_reg_next  = MODE_AUTO;
        end
        CMD_SET_TARGET: begin
          auto_speed_next = clamp_lim(in_item.speed_arg, limits.speed_limit);
          auto_turn_next  = clamp_lim(in_item.turn_arg, limits.turn_limit);
          mode_reg_next   = MODE_AUTO;
        end
        CMD_ROTATE: begin
          auto_speed_next = '0;
          auto_turn_next  = clamp_lim(in_item.turn_arg, limits.turn_limit);
          mode_reg_next   = MODE_AUTO;
        end
        CMD_STRAIGHT: begin
          auto_speed_next = clamp_lim(in_item.speed_arg, limits.speed_limit);
          auto_turn_next  = '0;
          mode_reg_next   = MODE_AUTO;
        end
        CMD_STOP: begin
          if (speed_mag > BRAKE_THRESHOLD && limits.brake_ticks != '0) begin
            auto_speed_next = cur_speed[FIELD_W-1] ? signed'(brake_mag) :
                                                     signed'(-brake_mag);
            auto_turn_next  = '0;
            mode_reg_next   = MODE_AUTO;
            brake_left_next = limits.brake_ticks;
          end else begin
            auto_speed_next = '0;
            auto_turn_next  = '0;
            mode_reg_next   = MODE_STOP;
            brake_left_next = '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Handshake: the input register moves on whenever the result register is free.
  assign adv       = in_busy && (!out_busy || res.ready);
  assign cmd.ready = !in_busy || adv;
  assign res.valid   = out_busy;
  assign res.payload = out_item;

  // Control registers and block state.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_busy    <= 1'b0;
      out_busy   <= 1'b0;
      mode_reg   <= MODE_MANUAL;
      auto_speed <= '0;
      auto_turn  <= '0;
      cur_speed  <= '0;
      cur_turn   <= '0;
      brake_left <= '0;
    end else begin
      if (cmd.valid && cmd.ready) begin
        in_busy <= 1'b1;
      end else if (adv) begin
        in_busy <= 1'b0;
      end
      if (adv) begin
        out_busy   <= 1'b1;
        mode_reg   <= mode_reg_next;
        auto_speed <= auto_speed_next;
        auto_turn  <= auto_turn_next;
        cur_speed  <= cur_speed_next;
        cur_turn   <= cur_turn_next;
        brake_left <= brake_left_next;
      end else if (res.ready) begin
        out_busy <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_item <= cmd.payload;
    end
    if (adv) begin
      out_item.drive_speed <= cur_speed_next;
      out_item.drive_turn  <= cur_turn_next;
      out_item.mode_now    <= mode_reg_next;
      out_item.braking     <= (brake_left_next != '0);
    end
  end

  // A brake pulse only runs in auto mode.
  a_brake_auto: assert property (@(posedge clk) disable iff (rst)
    brake_left != '0 |-> mode_reg == MODE_AUTO)
    else $error("brake pulse outside auto mode");

  // A reported brake pulse comes with auto mode.
  a_res_brake_auto: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.payload.braking) |-> res.payload.mode_now == MODE_AUTO)
    else $error("braking result without auto mode");

  // A held request stays in the input register until the result stage frees.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_busy && !adv) |=> in_busy)
    else $error("request lost from input register");

  // Slewed speed never reaches the most negative code.
  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    cur_speed != {1'b1, {(FIELD_W-1){1'b0}}})
    else $error("speed setpoint out of range");

endmodule

`default_nettype wire

[rtl/core/msr_cfg_regs.sv]
// Configuration register file with limits capped to the value range.
`default_nettype none

module msr_cfg_regs #(
  parameter int VALUE_WIDTH = msr_pkg::VALUE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  msr_chan_if.sink            cfg,
  output msr_pkg::msr_limits_t limits
);
  import msr_pkg::*;

  // Largest positive value of VALUE_WIDTH bits, as seen by a 15-bit limit.
  localparam logic [LIMIT_W-1:0] LIM_CAP = (VALUE_WIDTH - 1 >= LIMIT_W) ?
    {LIMIT_W{1'b1}} : LIMIT_W'((64'd1 << (VALUE_WIDTH - 1)) - 64'd1);

  logic [LIMIT_W-1:0] speed_limit;
  logic [LIMIT_W-1:0] turn_limit;
  logic [LIMIT_W-1:0] speed_rate;
  logic [LIMIT_W-1:0] turn_rate;
  logic [TICKS_W-1:0] brake_ticks;

  // Writes are always taken.
  assign cfg.ready = 1'b1;

  // Register writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_limit <= SPEED_LIMIT_RST;
      turn_limit  <= TURN_LIMIT_RST;
      speed_rate  <= SPEED_RATE_RST;
      turn_rate   <= TURN_RATE_RST;
      brake_ticks <= BRAKE_TICKS_RST;
    end else if (cfg.valid) begin
      case (cfg.payload.index)
        CFG_SPEED_LIMIT: speed_limit <= cfg.payload.data[LIMIT_W-1:0];
        CFG_TURN_LIMIT:  turn_limit  <= cfg.payload.data[LIMIT_W-1:0];
        CFG_SPEED_RATE:  speed_rate  <= cfg.payload.data[LIMIT_W-1:0];
        CFG_TURN_RATE:   turn_rate   <= cfg.payload.data[LIMIT_W-1:0];
        CFG_BRAKE_TICKS: brake_ticks <= cfg.payload.data[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  // Limits above the value range are capped to its largest positive value.
  always_comb begin
    limits.speed_limit = (speed_limit > LIM_CAP) ? LIM_CAP : speed_limit;
    limits.turn_limit  = (turn_limit > LIM_CAP) ? LIM_CAP : turn_limit;
    limits.speed_rate  = speed_rate;
    limits.turn_rate   = turn_rate;
    limits.brake_ticks = brake_ticks;
  end

endmodule

`default_nettype wire

[rtl/core/msr_slew.sv]
// One channel of target clamping and slew-rate limiting.
`default_nettype none

module msr_slew (
  input  logic signed [msr_pkg::FIELD_W-1:0] cur,
  input  logic signed [msr_pkg::FIELD_W-1:0] want,
  input  logic [msr_pkg::LIMIT_W-1:0]        limit,
  input  logic [msr_pkg::LIMIT_W-1:0]        step,
  output logic signed [msr_pkg::FIELD_W-1:0] next
);
  import msr_pkg::*;

  logic signed [FIELD_W-1:0] target;
  logic signed [FIELD_W+1:0] diff;
  logic signed [FIELD_W+1:0] pos_step;
  logic signed [FIELD_W+1:0] neg_step;
  logic signed [FIELD_W+1:0] delta;
  logic signed [FIELD_W+1:0] sum;

  // Clamp the target, then move toward it by at most one step.
  always_comb begin
    target   = clamp_lim(want, limit);
    diff     = {{2{target[FIELD_W-1]}}, target} - {{2{cur[FIELD_W-1]}}, cur};
    pos_step = signed'({3'b000, step});
    neg_step = -pos_step;
    if (diff > pos_step) begin
      delta = pos_step;
    end else if (diff < neg_step) begin
      delta = neg_step;
    end else begin
      delta = diff;
    end
    sum  = {{2{cur[FIELD_W-1]}}, cur} + delta;
    next = sum[FIELD_W-1:0];
  end

endmodule

`default_nettype wire

[sim/msr_result_checker.sv]
// Checker for the motion setpoint ramp: predicts every result and compares it with the block's.
`timescale 1ns / 100ps

module msr_result_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  logic              cmd_ready,
  input  msr_pkg::msr_cmd_t cmd_payload,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  msr_pkg::msr_cfg_t cfg_payload,
  input  logic              res_valid,
  input  logic              res_ready,
  input  msr_pkg::msr_res_t res_payload,
  output int                error_count,
  output int                pending,
  output int                effective_count,
  output int                checked_count,
  output int                braking_count
);
  import msr_pkg::*;

  // Limits are capped to the largest positive value of the value range.
  localparam int VALUE_MAX    = (1 << (VALUE_WIDTH_DEF - 1)) - 1;
  localparam int REPORT_LIMIT = 10;

  // Results still owed by the block, oldest first.
  msr_res_t setpoint_q[$];

  // Predicted state of the ramp.
  msr_mode_t drive_mode;
  int        hold_speed;
  int        hold_turn;
  int        ramp_speed;
  int        ramp_turn;
  int        brake_count;

  // Predicted register contents.
  int lim_speed;
  int lim_turn;
  int rate_speed;
  int rate_turn;
  int brake_len;

  function automatic int clamp_sym(input int v, input int lim);
    int cap;
    cap = (lim > VALUE_MAX) ? VALUE_MAX : lim;
    if (v > cap) return cap;
    if (v < -cap) return -cap;
    return v;
  endfunction

  function automatic int slew_toward(input int cur, input int want, input int step);
    int delta;
    delta = want - cur;
    if (delta > step) delta = step;
    if (delta < -step) delta = -step;
    return cur + delta;
  endfunction

  task automatic enter_stop();
    hold_speed  = 0;
    hold_turn   = 0;
    drive_mode  = MODE_STOP;
    brake_count = 0;
  endtask

  // Advance the predicted state by one request and form the result it yields.
  task automatic predict_setpoint(input msr_cmd_t req, output msr_res_t want);
    int goal_speed;
    int goal_turn;
    int mag;
    int pull;
    if (req.command == CMD_TICK) begin
      goal_speed = 0;
      goal_turn  = 0;
      if (drive_mode == MODE_MANUAL) begin
        goal_speed = int'(req.remote_speed);
        goal_turn  = int'(req.remote_turn);
      end else if (drive_mode == MODE_AUTO) begin
        goal_speed = hold_speed;
        goal_turn  = hold_turn;
      end
      ramp_speed = slew_toward(ramp_speed, clamp_sym(goal_speed, lim_speed), rate_speed);
      ramp_turn  = slew_toward(ramp_turn, clamp_sym(goal_turn, lim_turn), rate_turn);
      if (brake_count != 0) begin
        brake_count--;
        if (brake_count == 0) enter_stop();
      end
    end else if (brake_count == 0) begin
      // Everything but a tick is dropped while a brake pulse runs.
      case (req.command)
        CMD_SET_MODE: begin
          if (req.mode_value <= MODE_AUTO && req.mode_value != drive_mode) begin
            drive_mode = msr_mode_t'(req.mode_value);
            if (drive_mode != MODE_AUTO) begin
              hold_speed = 0;
              hold_turn  = 0;
            end
          end
        end
        CMD_FORWARD: begin
          hold_speed = clamp_sym(int'(req.speed_arg), lim_speed);
          drive_mode = MODE_AUTO;
        end
        CMD_TURN: begin
          hold_turn  = clamp_sym(int'(req.turn_arg), lim_turn);
          drive_mode = MODE_AUTO;
        end
        CMD_SET_TARGET: begin
          hold_speed = clamp_sym(int'(req.speed_arg), lim_speed);
          hold_turn  = clamp_sym(int'(req.turn_arg), lim_turn);
          drive_mode = MODE_AUTO;
        end
        CMD_ROTATE: begin
          hold_speed = 0;
          hold_turn  = clamp_sym(int'(req.turn_arg), lim_turn);
          drive_mode = MODE_AUTO;
        end
        CMD_STRAIGHT: begin
          hold_speed = clamp_sym(int'(req.speed_arg), lim_speed);
          hold_turn  = 0;
          drive_mode = MODE_AUTO;
        end
        CMD_STOP: begin
          // A moving stop first pushes back at 154/256 of the speed.
          mag = (ramp_speed < 0) ? -ramp_speed : ramp_speed;
          if (mag > int'(BRAKE_THRESHOLD) && brake_len != 0) begin
            pull        = (mag * int'(BRAKE_NUM)) >>> 8;
            hold_speed  = (ramp_speed < 0) ? pull : -pull;
            hold_turn   = 0;
            drive_mode  = MODE_AUTO;
            brake_count = brake_len;
          end else begin
            enter_stop();
          end
        end
        default: ;
      endcase
    end
    want.drive_speed = 16'(ramp_speed);
    want.drive_turn  = 16'(ramp_turn);
    want.mode_now    = drive_mode;
    want.braking     = (brake_count != 0);
  endtask

  // Track register writes, predict on each request and check each result.
  always @(posedge clk) begin
    msr_res_t want;
    msr_res_t got;
    if (rst) begin
      setpoint_q.delete();
      drive_mode      = MODE_MANUAL;
      hold_speed      = 0;
      hold_turn       = 0;
      ramp_speed      = 0;
      ramp_turn       = 0;
      brake_count     = 0;
      lim_speed       = int'(SPEED_LIMIT_RST);
      lim_turn        = int'(TURN_LIMIT_RST);
      rate_speed      = int'(SPEED_RATE_RST);
      rate_turn       = int'(TURN_RATE_RST);
      brake_len       = int'(BRAKE_TICKS_RST);
      error_count     = 0;
      effective_count = 0;
      checked_count   = 0;
      braking_count   = 0;
    end else begin
      if (res_valid && res_ready) begin
        got = res_payload;
        if (setpoint_q.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $display("%0t: result with none expected: speed %0d turn %0d mode %0d braking %0b",
                     $realtime, got.drive_speed, got.drive_turn, got.mode_now, got.braking);
          end
        end else begin
          want = setpoint_q.pop_front();
          checked_count++;
          if (got.braking) braking_count++;
          if (got.drive_speed !== want.drive_speed || got.drive_turn !== want.drive_turn ||
              got.mode_now !== want.mode_now || got.braking !== want.braking) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
              $display("%0t: result %0d mismatch: expected speed %0d turn %0d mode %0d braking %0b",
                       $realtime, checked_count, want.drive_speed, want.drive_turn,
                       want.mode_now, want.braking);
              $display("%0t: result %0d mismatch: actual   speed %0d turn %0d mode %0d braking %0b",
                       $realtime, checked_count, got.drive_speed, got.drive_turn,
                       got.mode_now, got.braking);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_payload.index)
          CFG_SPEED_LIMIT: lim_speed  = int'(cfg_payload.data[LIMIT_W-1:0]);
          CFG_TURN_LIMIT:  lim_turn   = int'(cfg_payload.data[LIMIT_W-1:0]);
          CFG_SPEED_RATE:  rate_speed = int'(cfg_payload.data[LIMIT_W-1:0]);
          CFG_TURN_RATE:   rate_turn  = int'(cfg_payload.data[LIMIT_W-1:0]);
          CFG_BRAKE_TICKS: brake_len  = int'(cfg_payload.data[TICKS_W-1:0]);
          default: ;
        endcase
      end
      if (cmd_valid && cmd_ready) begin
        if (cmd_payload.command == CMD_TICK || brake_count == 0) effective_count++;
        predict_setpoint(cmd_payload, want);
        setpoint_q.push_back(want);
      end
    end
    pending = setpoint_q.size();
  end

endmodule

[sim/testbench.sv]
// Top of the motion setpoint ramp testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
  import msr_pkg::*;

  // Mode value outside the defined modes; set_mode must ignore it.
  localparam logic [1:0] MODE_INVALID = 2'd3;
  localparam int IDLE_LIMIT = 2000;
  localparam int END_CYCLES = 8;

  logic clk;
  logic rst;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   idle_cycles = 0;
  int   request_count = 0;
  int   stop_count = 0;
  int   settings_used = 0;

  int error_count;
  int pending;
  int effective_count;
  int checked_count;
  int braking_count;

  msr_chan_if #(.payload_t(msr_cmd_t)) cmd_ch ();
  msr_chan_if #(.payload_t(msr_cfg_t)) cfg_ch ();
  msr_chan_if #(.payload_t(msr_res_t)) res_ch ();

  motion_setpoint_ramp dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .cfg (cfg_ch),
    .res (res_ch)
  );

  msr_result_checker result_check (
    .clk             (clk),
    .rst             (rst),
    .cmd_valid       (cmd_ch.valid),
    .cmd_ready       (cmd_ch.ready),
    .cmd_payload     (cmd_ch.payload),
    .cfg_valid       (cfg_ch.valid),
    .cfg_ready       (cfg_ch.ready),
    .cfg_payload     (cfg_ch.payload),
    .res_valid       (res_ch.valid),
    .res_ready       (res_ch.ready),
    .res_payload     (res_ch.payload),
    .error_count     (error_count),
    .pending         (pending),
    .effective_count (effective_count),
    .checked_count   (checked_count),
    .braking_count   (braking_count)
  );

  // Clock with a 12 ns period.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Result side stalls at the rate of the current phase.
  always @(negedge clk) begin
    res_ch.ready = ($urandom_range(99) >= rx_idle_pct);
  end

  // Watchdog on cycles in which no request of any channel moves.
  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
        (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog expired after %0d cycles without progress.", IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Send one request, with random idle cycles ahead of it.
  task automatic push_request(input msr_cmd_t req);
    while ($urandom_range(99) < tx_idle_pct) @(negedge clk);
    cmd_ch.payload = req;
    cmd_ch.valid   = 1'b1;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    @(negedge clk);
    cmd_ch.valid = 1'b0;
    request_count++;
    if (req.command == CMD_STOP) stop_count++;
  endtask

  task automatic write_register(input msr_cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.payload = '{index: idx, data: value};
    cfg_ch.valid   = 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic wait_drained();
    wait (pending == 0);
    @(negedge clk);
  endtask

  // Write all five registers; unused upper data bits carry random values.
  task automatic apply_setting(input logic [LIMIT_W-1:0] speed_lim,
                               input logic [LIMIT_W-1:0] turn_lim,
                               input logic [LIMIT_W-1:0] speed_rate,
                               input logic [LIMIT_W-1:0] turn_rate,
                               input logic [TICKS_W-1:0] ticks);
    logic [7:0] pad;
    pad = 8'($urandom);
    write_register(CFG_SPEED_LIMIT, {pad[0], speed_lim});
    write_register(CFG_TURN_LIMIT, {pad[1], turn_lim});
    write_register(CFG_SPEED_RATE, {pad[2], speed_rate});
    write_register(CFG_TURN_RATE, {pad[3], turn_rate});
    write_register(CFG_BRAKE_TICKS, {pad, ticks});
    settings_used++;
  endtask

  function automatic msr_cmd_t make_request(input msr_cmd_code_t code, input logic [1:0] mv,
                                            input logic signed [FIELD_W-1:0] sa,
                                            input logic signed [FIELD_W-1:0] ta,
                                            input logic signed [FIELD_W-1:0] rs,
                                            input logic signed [FIELD_W-1:0] rt);
    msr_cmd_t req;
    req.command      = code;
    req.mode_value   = mv;
    req.speed_arg    = sa;
    req.turn_arg     = ta;
    req.remote_speed = rs;
    req.remote_turn  = rt;
    return req;
  endfunction

  // Mix of full-range values, extremes and values near typical limits.
  function automatic logic signed [FIELD_W-1:0] random_value();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'(int'($urandom_range(4000)) - 2000);
      2: begin
        case ($urandom_range(3))
          0: return 16'sh7FFF;
          1: return 16'sh8000;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return 16'(int'($urandom_range(1200)) - 600);
    endcase
  endfunction

  // Ticks dominate so that values actually ramp; stops are frequent enough to brake often.
  function automatic msr_cmd_t random_request();
    msr_cmd_t req;
    int pick;
    pick             = $urandom_range(99);
    req.mode_value   = 2'($urandom_range(3));
    req.speed_arg    = random_value();
    req.turn_arg     = random_value();
    req.remote_speed = random_value();
    req.remote_turn  = random_value();
    if (pick < 45) req.command = CMD_TICK;
    else if (pick < 52) req.command = CMD_SET_MODE;
    else if (pick < 59) req.command = CMD_FORWARD;
    else if (pick < 66) req.command = CMD_TURN;
    else if (pick < 73) req.command = CMD_SET_TARGET;
    else if (pick < 80) req.command = CMD_ROTATE;
    else if (pick < 87) req.command = CMD_STRAIGHT;
    else req.command = CMD_STOP;
    return req;
  endfunction

  // Send n random requests, now and then pausing until every result is back.
  task automatic run_random(input int n);
    repeat (n) begin
      if ($urandom_range(99) == 0) wait_drained();
      push_request(random_request());
    end
  endtask

  task automatic run_block(input logic [LIMIT_W-1:0] speed_lim, input logic [LIMIT_W-1:0] turn_lim,
                           input logic [LIMIT_W-1:0] speed_rate,
                           input logic [LIMIT_W-1:0] turn_rate,
                           input logic [TICKS_W-1:0] ticks, input int tx_pct, input int rx_pct,
                           input int n);
    wait_drained();
    apply_setting(speed_lim, turn_lim, speed_rate, turn_rate, ticks);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    run_random(n);
  endtask

  // Directed requests: field extremes, every command and the mode corner cases.
  task automatic run_directed();
    // Manual ticks with remote values past both limits, at reset limits.
    push_request(make_request(CMD_TICK, MODE_STOP, '0, '0, 16'sh7FFF, 16'sh8000));
    push_request(make_request(CMD_TICK, MODE_STOP, '1, '1, 16'sh8000, 16'sh7FFF));
    // An undefined mode and the mode already set change nothing.
    push_request(make_request(CMD_SET_MODE, MODE_INVALID, '0, '0, '0, '0));
    push_request(make_request(CMD_SET_MODE, MODE_MANUAL, '0, '0, '0, '0));
    // Each target command; all but the rotate turn argument lie beyond the limits.
    push_request(make_request(CMD_FORWARD, MODE_AUTO, 16'sh7FFF, '0, '0, '0));
    push_request(make_request(CMD_TURN, MODE_AUTO, '0, 16'sh8000, '0, '0));
    push_request(make_request(CMD_SET_TARGET, MODE_AUTO, 16'sh8000, 16'sh7FFF, '1, '1));
    push_request(make_request(CMD_ROTATE, MODE_MANUAL, 16'sh7FFF, 16'sd12345, '0, '0));
    push_request(make_request(CMD_STRAIGHT, MODE_MANUAL, 16'sh8000, 16'sh7FFF, '0, '0));
    push_request(make_request(CMD_TICK, MODE_STOP, '0, '0, 16'sh7FFF, 16'sh7FFF));
    // Leaving auto clears the targets; stopping while slow stops at once.
    push_request(make_request(CMD_SET_MODE, MODE_STOP, '0, '0, '0, '0));
    push_request(make_request(CMD_TICK, MODE_STOP, '0, '0, 16'sh7FFF, 16'sh8000));
    push_request(make_request(CMD_SET_MODE, MODE_AUTO, '0, '0, '0, '0));
    push_request(make_request(CMD_STOP, MODE_STOP, '0, '0, '0, '0));
    push_request(make_request(CMD_SET_MODE, MODE_MANUAL, '0, '0, '0, '0));
    push_request(make_request(CMD_TICK, MODE_STOP, '0, '0, '0, '0));
    // Short brake pulse with a faster speed step.
    wait_drained();
    apply_setting(SPEED_LIMIT_RST, TURN_LIMIT_RST, 15'd30, TURN_RATE_RST, 8'd2);
    push_request(make_request(CMD_FORWARD, MODE_AUTO, 16'sd2000, '0, '0, '0));
    push_request(make_request(CMD_TICK, MODE_STOP, '0, '0, '0, '0));
    push_request(make_request(CMD_TICK, MODE_STOP, '0, '0, '0, '0));
    push_request(make_request(CMD_STOP, MODE_STOP, '0, '0, '0, '0));
    // Commands during the pulse are dropped.
    push_request(make_request(CMD_FORWARD, MODE_AUTO, 16'sh7FFF, 16'sh7FFF, '0, '0));
    push_request(make_request(CMD_SET_MODE, MODE_MANUAL, '0, '0, '0, '0));
    push_request(make_request(CMD_TICK, MODE_STOP, '0, '0, 16'sh7FFF, '0));
    push_request(make_request(CMD_TICK, MODE_STOP, '0, '0, 16'sh7FFF, '0));
    push_request(make_request(CMD_TICK, MODE_STOP, '0, '0, 16'sh7FFF, '0));
  endtask

  // Reset, directed part, then random blocks under several register settings.
  initial begin
    rst            = 1'b1;
    cmd_ch.valid   = 1'b0;
    cmd_ch.payload = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.payload = '0;
    res_ch.ready   = 1'b0;
    tx_idle_pct    = 9;
    rx_idle_pct    = 77;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    run_directed();
    run_block(15'd32767, 15'd32767, 15'd32767, 15'd32767, 8'd255, 9, 77, 320);
    run_block(15'd0, 15'd0, 15'd0, 15'd0, 8'd0, 9, 77, 160);
    run_block(15'd2000, 15'd500, 15'd150, 15'd40, 8'd3, 77, 9, 320);
    run_block(15'd1500, 15'd20000, 15'd300, 15'd1000, 8'd12, 77, 9, 300);
    run_block(15'd800, 15'd32767, 15'd25, 15'd7, 8'd1, 0, 0, 300);

    wait_drained();
    repeat (END_CYCLES) @(negedge clk);

    $display("Sent %0d requests, %0d of them stops; %0d were not dropped by a brake pulse.",
             request_count, stop_count, effective_count);
    $display("Checked %0d results, %0d while braking, under %0d register settings.",
             checked_count, braking_count, settings_used);
    if (error_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/msr_pkg.sv
rtl/core/msr_chan_if.sv
rtl/core/msr_cfg_regs.sv
rtl/core/msr_slew.sv
rtl/core/motion_setpoint_ramp.sv
sim/msr_result_checker.sv
sim/testbench.sv
